// File: hdl/hrt_pkg.sv
// Shared types, codes and constants for the HTTP request head tokenizer.
// No dependencies; used by every module of the block.
`default_nettype none

package hrt_pkg;

  localparam int OFF_W        = 13;
  localparam int KIND_W       = 3;
  localparam int MAX_LINE_DEF = 4096;
  localparam int HOST_LEN     = 5;
  localparam int CONN_LEN     = 11;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_SP  = 8'd32;

  localparam logic [KIND_W-1:0] KIND_REQ_LINE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HOST       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CONNECTION = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END_HEAD   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD_CR     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NO_BLANK   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_INCOMPLETE = 3'd6;
  localparam logic [KIND_W-1:0] KIND_TOO_LONG   = 3'd7;

  localparam logic [1:0] PH_REQ  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  method_end;
    logic [OFF_W-1:0]  uri_start;
    logic [OFF_W-1:0]  uri_end;
    logic [OFF_W-1:0]  version_start;
    logic [OFF_W-1:0]  value_start;
    logic [OFF_W-1:0]  line_length;
  } res_t;

  typedef struct packed {
    logic host_hit;
    logic conn_hit;
  } prefix_hit_t;

  // lower-case "host:"
  function automatic logic [7:0] host_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h68;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h73;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // lower-case "connection:"
  function automatic logic [7:0] conn_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h6e;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h63;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h6f;
      4'd9:    c = 8'h6e;
      4'd10:   c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hrt_prefix.sv
// Case-insensitive compare of one header byte against the Host: and
// Connection: prefixes at a given line offset. Depends on hrt_pkg.
`default_nettype none

module hrt_prefix (
  input  wire logic [7:0]         data_byte,
  input  wire logic [3:0]         idx,
  output hrt_pkg::prefix_hit_t    hit
);

  logic [7:0] lc;

  always_comb begin
    if (data_byte inside {[8'h41:8'h5a]}) begin
      lc = data_byte + 8'd32;
    end else begin
      lc = data_byte;
    end
    hit.host_hit = (lc == hrt_pkg::host_char(idx));
    hit.conn_hit = (lc == hrt_pkg::conn_char(idx));
  end

endmodule

`default_nettype wire

// File: hdl/hrt_core.sv
// Parse state and per-byte next-state / result logic of the tokenizer.
// Depends on hrt_pkg and hrt_prefix.
`default_nettype none

module hrt_core #(
  parameter int MAX_LINE = hrt_pkg::MAX_LINE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  output logic            res_valid,
  output hrt_pkg::res_t   res
);

  localparam int POS_W = $clog2(MAX_LINE + 1);

  logic [1:0]       phase, phase_next, ph_c;
  logic [POS_W-1:0] pos, pos_next, pos_c;
  logic             cr_pending, cr_pending_next, crp_c;
  logic [POS_W-1:0] first_blank, first_blank_next, fb_c;
  logic             blank_seen, blank_seen_next, bs_c;
  logic [POS_W-1:0] first_nonblank, first_nonblank_next, fna_c;
  logic [POS_W-1:0] last_blank, last_blank_next, lb_c;
  logic [POS_W-1:0] last_word_end, last_word_end_next, lwe_c;
  logic [1:0]       cand, cand_next, cand_c, cand_upd;
  logic [POS_W-1:0] value_begin, value_begin_next, vb_c;

  logic [POS_W-1:0] uri_s, uri_e;
  logic             blank;
  hrt_pkg::prefix_hit_t hit;

  hrt_prefix u_prefix (
    .data_byte (data_byte),
    .idx       (pos_c[3:0]),
    .hit       (hit)
  );

  always_comb begin
    // a first byte starts from the reset state
    ph_c   = first_byte ? hrt_pkg::PH_REQ : phase;
    pos_c  = first_byte ? '0 : pos;
    crp_c  = first_byte ? 1'b0 : cr_pending;
    fb_c   = first_byte ? '0 : first_blank;
    bs_c   = first_byte ? 1'b0 : blank_seen;
    fna_c  = first_byte ? '0 : first_nonblank;
    lb_c   = first_byte ? '0 : last_blank;
    lwe_c  = first_byte ? '0 : last_word_end;
    cand_c = first_byte ? 2'b11 : cand;
    vb_c   = first_byte ? '0 : value_begin;

    phase_next          = ph_c;
    pos_next            = pos_c;
    cr_pending_next     = crp_c;
    first_blank_next    = fb_c;
    blank_seen_next     = bs_c;
    first_nonblank_next = fna_c;
    last_blank_next     = lb_c;
    last_word_end_next  = lwe_c;
    cand_next           = cand_c;
    value_begin_next    = vb_c;

    res_valid = 1'b0;
    res       = '0;
    blank     = (data_byte == hrt_pkg::CH_SP) || (data_byte == hrt_pkg::CH_TAB);
    cand_upd  = cand_c;

    uri_s = (fna_c != '0) ? fna_c : pos_c;
    uri_e = (lwe_c < uri_s) ? uri_s : lwe_c;

    if ((ph_c == hrt_pkg::PH_REQ) || (ph_c == hrt_pkg::PH_HDR)) begin
      if (crp_c) begin
        cr_pending_next = 1'b0;
        if (data_byte == hrt_pkg::CH_LF) begin
          if (ph_c == hrt_pkg::PH_REQ) begin
            phase_next      = hrt_pkg::PH_HDR;
            res_valid       = 1'b1;
            res.line_length = hrt_pkg::OFF_W'(pos_c);
            if (!bs_c) begin
              res.kind = hrt_pkg::KIND_NO_BLANK;
            end else begin
              res.kind          = hrt_pkg::KIND_REQ_LINE;
              res.method_end    = hrt_pkg::OFF_W'(fb_c);
              res.uri_start     = hrt_pkg::OFF_W'(uri_s);
              res.uri_end       = hrt_pkg::OFF_W'(uri_e);
              res.version_start = hrt_pkg::OFF_W'(lb_c);
            end
          end else if (pos_c == '0) begin
            phase_next = hrt_pkg::PH_DONE;
            res_valid  = 1'b1;
            res.kind   = hrt_pkg::KIND_END_HEAD;
          end else if (cand_c[0] && (pos_c >= POS_W'(hrt_pkg::HOST_LEN))) begin
            res_valid       = 1'b1;
            res.kind        = hrt_pkg::KIND_HOST;
            res.value_start = hrt_pkg::OFF_W'((vb_c != '0) ? vb_c : pos_c);
            res.line_length = hrt_pkg::OFF_W'(pos_c);
          end else if (cand_c[1] && (pos_c >= POS_W'(hrt_pkg::CONN_LEN))) begin
            res_valid       = 1'b1;
            res.kind        = hrt_pkg::KIND_CONNECTION;
            res.value_start = hrt_pkg::OFF_W'((vb_c != '0) ? vb_c : pos_c);
            res.line_length = hrt_pkg::OFF_W'(pos_c);
          end
          pos_next            = '0;
          first_blank_next    = '0;
          blank_seen_next     = 1'b0;
          first_nonblank_next = '0;
          last_blank_next     = '0;
          last_word_end_next  = '0;
          cand_next           = 2'b11;
          value_begin_next    = '0;
        end else begin
          phase_next      = hrt_pkg::PH_STOP;
          res_valid       = 1'b1;
          res.kind        = hrt_pkg::KIND_BAD_CR;
          res.line_length = hrt_pkg::OFF_W'(pos_c);
        end
      end else if (data_byte == hrt_pkg::CH_CR) begin
        cr_pending_next = 1'b1;
      end else if (pos_c >= POS_W'(MAX_LINE)) begin
        phase_next      = hrt_pkg::PH_STOP;
        res_valid       = 1'b1;
        res.kind        = hrt_pkg::KIND_TOO_LONG;
        res.line_length = hrt_pkg::OFF_W'(pos_c);
      end else begin
        pos_next = pos_c + 1'b1;
        if (ph_c == hrt_pkg::PH_REQ) begin
          if (blank) begin
            if (!(bs_c && (lb_c == pos_c))) begin
              last_word_end_next = pos_c;
            end
            if (!bs_c) begin
              blank_seen_next  = 1'b1;
              first_blank_next = pos_c;
            end
            last_blank_next = pos_c + 1'b1;
          end else if (bs_c && (fna_c == '0)) begin
            first_nonblank_next = pos_c;
          end
        end else begin
          if (pos_c < POS_W'(hrt_pkg::CONN_LEN)) begin
            if ((pos_c < POS_W'(hrt_pkg::HOST_LEN)) && !hit.host_hit) begin
              cand_upd[0] = 1'b0;
            end
            if (!hit.conn_hit) begin
              cand_upd[1] = 1'b0;
            end
          end
          cand_next = cand_upd;
          if ((vb_c == '0) && !blank &&
              ((cand_upd[0] && (pos_c >= POS_W'(hrt_pkg::HOST_LEN))) ||
               (cand_upd[1] && (pos_c >= POS_W'(hrt_pkg::CONN_LEN))))) begin
            value_begin_next = pos_c;
          end
        end
      end

      if (last_byte && !res_valid &&
          ((phase_next == hrt_pkg::PH_REQ) || (phase_next == hrt_pkg::PH_HDR))) begin
        res_valid       = 1'b1;
        res.kind        = hrt_pkg::KIND_INCOMPLETE;
        res.line_length = hrt_pkg::OFF_W'(pos_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hrt_pkg::PH_REQ;
      pos            <= '0;
      cr_pending     <= 1'b0;
      first_blank    <= '0;
      blank_seen     <= 1'b0;
      first_nonblank <= '0;
      last_blank     <= '0;
      last_word_end  <= '0;
      cand           <= 2'b11;
      value_begin    <= '0;
    end else if (en) begin
      phase          <= phase_next;
      pos            <= pos_next;
      cr_pending     <= cr_pending_next;
      first_blank    <= first_blank_next;
      blank_seen     <= blank_seen_next;
      first_nonblank <= first_nonblank_next;
      last_blank     <= last_blank_next;
      last_word_end  <= last_word_end_next;
      cand           <= cand_next;
      value_begin    <= value_begin_next;
    end
  end

  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    en && !first_byte && ((phase == hrt_pkg::PH_DONE) || (phase == hrt_pkg::PH_STOP))
    |-> !res_valid)
    else $error("result produced after head ended or stopped");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_LINE))
    else $error("line position beyond line limit");

  a_cr_phase: assert property (@(posedge clk) disable iff (rst)
    cr_pending |-> ((phase == hrt_pkg::PH_REQ) || (phase == hrt_pkg::PH_HDR)))
    else $error("pending CR outside an active phase");

  a_too_long_len: assert property (@(posedge clk) disable iff (rst)
    en && res_valid && (res.kind == hrt_pkg::KIND_TOO_LONG)
    |-> (res.line_length == hrt_pkg::OFF_W'(MAX_LINE)))
    else $error("too-long result with wrong length");

endmodule

`default_nettype wire

// File: hdl/http_request_head_tokenizer.sv
// Top level of the HTTP request head tokenizer: input register, parse core,
// result register. Depends on hrt_pkg, hrt_core and hrt_prefix.
`default_nettype none

// Takes one byte of a request head per item and returns at most one result
// per byte. A new byte is accepted every cycle while m_tready does not stall
// the output; an accepted byte sits in the input register, then its result
// loads into the result register when the core advances, and stalls on
// m_tready back up through both registers.
// Bytes that give no result leave the master side idle. Offsets
// are counted from the start of each line; MAX_LINE sets the line limit and
// the width of the internal position counters, while the reported offsets
// are always 13 bits wide (masked). s_tuser[0] restarts parsing for a new
// request; s_tlast marks the last byte currently available.

module http_request_head_tokenizer #(
  parameter int MAX_LINE = hrt_pkg::MAX_LINE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic [0:0]  s_tuser,   // first_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // method_end, uri_start, uri_end,
                                      // version_start, value_start,
                                      // line_length, 2 zero bits
  output logic [2:0]       m_tuser    // kind
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_first;
  logic          in_last;
  logic          advance;
  logic          core_valid;
  hrt_pkg::res_t core_res;
  hrt_pkg::res_t res_q;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  hrt_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .data_byte  (in_byte),
    .first_byte (in_first),
    .last_byte  (in_last),
    .res_valid  (core_valid),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser[0];
      in_last  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= core_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid) begin
      res_q <= core_res;
    end
  end

  assign m_tuser = res_q.kind;
  assign m_tdata = {2'b00, res_q.line_length, res_q.value_start, res_q.version_start,
                    res_q.uri_end, res_q.uri_start, res_q.method_end};

  a_uri_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_q.kind == hrt_pkg::KIND_REQ_LINE)
    |-> (res_q.uri_end >= res_q.uri_start))
    else $error("URI range inverted");

  a_zero_offsets: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_q.kind != hrt_pkg::KIND_REQ_LINE)
    |-> (res_q.method_end == '0) && (res_q.uri_start == '0) &&
        (res_q.uri_end == '0) && (res_q.version_start == '0))
    else $error("request line offsets set on another kind");

  a_in_taken: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted item lost from input register");

endmodule

`default_nettype wire

// File: dv/tb_http_request_head_tokenizer.sv
// Testbench for http_request_head_tokenizer: drives request heads one byte per item,
// predicts each result and checks the result stream field by field.
// Depends on hrt_pkg and the http_request_head_tokenizer RTL.
`default_nettype none

module tb_http_request_head_tokenizer;

  localparam int LINE_LIMIT = hrt_pkg::MAX_LINE_DEF;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [0:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;

  http_request_head_tokenizer #(
    .MAX_LINE(LINE_LIMIT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // tokenizer state as predicted
  logic [1:0]                hd_phase;
  logic [hrt_pkg::OFF_W-1:0] line_pos;
  logic                      cr_wait;
  logic [hrt_pkg::OFF_W-1:0] blank_first;
  logic                      blank_found;
  logic [hrt_pkg::OFF_W-1:0] nonblank_after;
  logic [hrt_pkg::OFF_W-1:0] blank_last_next;
  logic [hrt_pkg::OFF_W-1:0] word_end;
  logic [3:0]                prefix_len;
  logic                      maybe_host;
  logic                      maybe_conn;
  logic [hrt_pkg::OFF_W-1:0] value_pos;

  string host_key = "host:";
  string conn_key = "connection:";

  hrt_pkg::res_t expected_tokens[$];
  logic [7:0]    head_bytes[$];
  int            errors = 0;
  int            live_items = 0;
  bit            idle_on = 1'b1;
  int            stall_left = 0;

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic clear_line();
    line_pos        = '0;
    cr_wait         = 1'b0;
    blank_first     = '0;
    blank_found     = 1'b0;
    nonblank_after  = '0;
    blank_last_next = '0;
    word_end        = '0;
    prefix_len      = '0;
    maybe_host      = 1'b1;
    maybe_conn      = 1'b1;
    value_pos       = '0;
  endtask

  task automatic clear_head();
    hd_phase = hrt_pkg::PH_REQ;
    clear_line();
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    logic [hrt_pkg::OFF_W-1:0] p;
    logic [7:0]                lc;
    logic                      blank;
    p     = line_pos;
    blank = (b == hrt_pkg::CH_SP) || (b == hrt_pkg::CH_TAB);
    if (hd_phase == hrt_pkg::PH_REQ) begin
      if (blank) begin
        if (!(blank_found && blank_last_next == p)) word_end = p;
        if (!blank_found) begin
          blank_found = 1'b1;
          blank_first = p;
        end
        blank_last_next = p + 1'b1;
      end else if (blank_found && nonblank_after == 0) begin
        nonblank_after = p;
      end
    end else begin
      if (p < hrt_pkg::CONN_LEN) begin
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (p < hrt_pkg::HOST_LEN && lc != host_key[p]) maybe_host = 1'b0;
        if (lc != conn_key[p]) maybe_conn = 1'b0;
        prefix_len = 4'(p + 1'b1);
      end
      if (value_pos == 0 && !blank &&
          ((maybe_host && p >= hrt_pkg::HOST_LEN) || (maybe_conn && p >= hrt_pkg::CONN_LEN)))
        value_pos = p;
    end
  endtask

  task automatic close_line(inout hrt_pkg::res_t r, output bit hit);
    logic [hrt_pkg::OFF_W-1:0] len;
    logic [hrt_pkg::OFF_W-1:0] us;
    logic [hrt_pkg::OFF_W-1:0] ue;
    len = line_pos;
    hit = 1'b0;
    if (hd_phase == hrt_pkg::PH_REQ) begin
      hd_phase      = hrt_pkg::PH_HDR;
      hit           = 1'b1;
      r.line_length = len;
      if (!blank_found) begin
        r.kind = hrt_pkg::KIND_NO_BLANK;
      end else begin
        us = (nonblank_after != 0) ? nonblank_after : len;
        ue = (word_end < us) ? us : word_end;
        r.kind          = hrt_pkg::KIND_REQ_LINE;
        r.method_end    = blank_first;
        r.uri_start     = us;
        r.uri_end       = ue;
        r.version_start = blank_last_next;
      end
    end else if (len == 0) begin
      hd_phase = hrt_pkg::PH_DONE;
      r.kind   = hrt_pkg::KIND_END_HEAD;
      hit      = 1'b1;
    end else if (maybe_host && prefix_len >= hrt_pkg::HOST_LEN) begin
      r.kind        = hrt_pkg::KIND_HOST;
      r.value_start = (value_pos != 0) ? value_pos : len;
      r.line_length = len;
      hit           = 1'b1;
    end else if (maybe_conn && prefix_len >= hrt_pkg::CONN_LEN) begin
      r.kind        = hrt_pkg::KIND_CONNECTION;
      r.value_start = (value_pos != 0) ? value_pos : len;
      r.line_length = len;
      hit           = 1'b1;
    end
    clear_line();
  endtask

  task automatic predict_token(input logic [7:0] b, input logic first, input logic last);
    hrt_pkg::res_t r;
    bit            hit;
    r   = '0;
    hit = 1'b0;
    if (first) clear_head();
    if (hd_phase == hrt_pkg::PH_REQ || hd_phase == hrt_pkg::PH_HDR) begin
      live_items++;
      if (cr_wait) begin
        cr_wait = 1'b0;
        if (b == hrt_pkg::CH_LF) begin
          close_line(r, hit);
        end else begin
          r.kind        = hrt_pkg::KIND_BAD_CR;
          r.line_length = line_pos;
          hd_phase      = hrt_pkg::PH_STOP;
          hit           = 1'b1;
        end
      end else if (b == hrt_pkg::CH_CR) begin
        cr_wait = 1'b1;
      end else if (line_pos >= LINE_LIMIT) begin
        r.kind        = hrt_pkg::KIND_TOO_LONG;
        r.line_length = line_pos;
        hd_phase      = hrt_pkg::PH_STOP;
        hit           = 1'b1;
      end else begin
        absorb_byte(b);
        line_pos = line_pos + 1'b1;
      end
      if (last && !hit && (hd_phase == hrt_pkg::PH_REQ || hd_phase == hrt_pkg::PH_HDR)) begin
        r.kind        = hrt_pkg::KIND_INCOMPLETE;
        r.line_length = line_pos;
        hit           = 1'b1;
      end
    end
    if (hit) expected_tokens.insert(expected_tokens.size(), r);
  endtask

  task automatic send_item(input logic [7:0] d, input logic first, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_token(d, first, last);
  endtask

  task automatic send_text(input string s, input bit first);
    for (int i = 0; i < s.len(); i++) send_item(s[i], first && i == 0, 1'b0);
  endtask

  task automatic send_line(input string s, input bit first);
    send_text(s, first);
    send_item(hrt_pkg::CH_CR, first && s.len() == 0, 1'b0);
    send_item(hrt_pkg::CH_LF, 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] rand_text_byte(input bit no_blank);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126))
                                      : 8'($urandom_range(0, 255));
    end while (c == hrt_pkg::CH_CR ||
               (no_blank && (c == hrt_pkg::CH_SP || c == hrt_pkg::CH_TAB)));
    return c;
  endfunction

  task automatic append_byte(input logic [7:0] c);
    head_bytes.insert(head_bytes.size(), c);
  endtask

  task automatic push_blanks(input int n);
    repeat (n) append_byte($urandom_range(0, 1) ? hrt_pkg::CH_SP : hrt_pkg::CH_TAB);
  endtask

  task automatic push_text(input int n, input bit no_blank);
    repeat (n) append_byte(rand_text_byte(no_blank));
  endtask

  task automatic push_key(input string k);
    logic [7:0] c;
    for (int i = 0; i < k.len(); i++) begin
      c = k[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      append_byte(c);
    end
  endtask

  task automatic push_crlf();
    append_byte(hrt_pkg::CH_CR);
    append_byte(hrt_pkg::CH_LF);
  endtask

  // one head with random content; sometimes cut short, corrupted or marked last early
  task automatic send_random_head();
    int    cut;
    int    last_at;
    int    idx;
    string key;
    head_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      push_text($urandom_range(0, 6), 1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(65, 90)));
      push_blanks($urandom_range(1, 3));
      push_text($urandom_range(0, 12), 1'b1);
      push_blanks($urandom_range(0, 3));
      push_text($urandom_range(0, 8), 1'b1);
      if ($urandom_range(0, 5) == 0) push_blanks($urandom_range(1, 2));
    end
    push_crlf();
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          push_key(host_key);
          push_blanks($urandom_range(0, 3));
        end
        2: begin
          push_key(conn_key);
          push_blanks($urandom_range(0, 3));
        end
        3: begin
          key = $urandom_range(0, 1) ? host_key : conn_key;
          push_key(key.substr(0, $urandom_range(0, key.len() - 2)));
        end
        default: push_text($urandom_range(1, 12), 1'b0);
      endcase
      push_text($urandom_range(0, 12), 1'b0);
      push_crlf();
    end
    if ($urandom_range(0, 7) != 0) push_crlf();

    if ($urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, head_bytes.size() - 1);
      head_bytes[idx] = $urandom_range(0, 1) ? hrt_pkg::CH_CR : 8'($urandom_range(0, 255));
    end
    cut = head_bytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut);
    last_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, cut - 1) : -1;
    for (int i = 0; i < cut; i++)
      send_item(head_bytes[i], i == 0,
                i == last_at || (i == cut - 1 && $urandom_range(0, 3) == 0));
  endtask

  task automatic test_request_line();
    send_line("GET\t/x  H", 1'b1);
    send_line("", 1'b0);
    send_line("A  ", 1'b1);
    send_line("XY", 1'b1);
    send_line("", 1'b1);
    send_line("", 1'b0);
  endtask

  task automatic test_header_match();
    send_line("GET / HTTP/1.1", 1'b1);
    send_text("HoSt:\t ", 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_line("", 1'b0);
    send_line("connection:  ", 1'b0);
    send_line("CONNECTION:close", 1'b0);
    send_line("Hostz:a", 1'b0);
    send_line("Host:", 1'b0);
    send_line("", 1'b0);
    send_text("zz", 1'b0);
  endtask

  task automatic test_line_errors();
    send_text("A", 1'b1);
    send_item(hrt_pkg::CH_CR, 1'b0, 1'b0);
    send_item("B", 1'b0, 1'b0);
    send_item("C", 1'b0, 1'b0);
    send_line("A B", 1'b1);
    send_text("Ho", 1'b0);
    send_item(hrt_pkg::CH_CR, 1'b0, 1'b0);
    send_item(hrt_pkg::CH_CR, 1'b0, 1'b0);
  endtask

  task automatic test_incomplete();
    send_item("G", 1'b1, 1'b0);
    send_item("E", 1'b0, 1'b1);
    send_text("T /", 1'b0);
    send_item(hrt_pkg::CH_CR, 1'b0, 1'b1);
    send_item(hrt_pkg::CH_LF, 1'b0, 1'b1);
    send_line("", 1'b0);
    send_item("x", 1'b0, 1'b1);
    send_item("Q", 1'b1, 1'b1);
    send_line(" /", 1'b0);
  endtask

  task automatic test_random_heads(input int n);
    int start;
    start = live_items;
    while (live_items - start < n) send_random_head();
  endtask

  task automatic test_noise(input int n);
    int         start;
    logic [7:0] b;
    start = live_items;
    while (live_items - start < n) begin
      case ($urandom_range(0, 7))
        0:       b = hrt_pkg::CH_CR;
        1:       b = hrt_pkg::CH_LF;
        2:       b = hrt_pkg::CH_SP;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_item(b, $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [hrt_pkg::OFF_W-1:0] want,
                             input logic [hrt_pkg::OFF_W-1:0] got);
    if (got !== want) flag_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    hrt_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_tokens.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d", m_tuser));
      end else begin
        want = expected_tokens.pop_front();
        check_field("kind", hrt_pkg::OFF_W'(want.kind), hrt_pkg::OFF_W'(m_tuser));
        check_field("method_end", want.method_end, m_tdata[12:0]);
        check_field("uri_start", want.uri_start, m_tdata[25:13]);
        check_field("uri_end", want.uri_end, m_tdata[38:26]);
        check_field("version_start", want.version_start, m_tdata[51:39]);
        check_field("value_start", want.value_start, m_tdata[64:52]);
        check_field("line_length", want.line_length, m_tdata[77:65]);
        check_field("pad", '0, hrt_pkg::OFF_W'(m_tdata[79:78]));
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    s_tlast  <= 1'b0;
    clear_head();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_request_line();
    test_header_match();
    test_line_errors();
    test_incomplete();
    test_random_heads(280);
    test_noise(30);
    idle_on = 1'b0;
    test_random_heads(80);
    s_tvalid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0)
      $display("http_request_head_tokenizer test passed");
    else
      $display("http_request_head_tokenizer test failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("http_request_head_tokenizer test failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
hdl/hrt_pkg.sv
hdl/hrt_prefix.sv
hdl/hrt_core.sv
hdl/http_request_head_tokenizer.sv
dv/tb_http_request_head_tokenizer.sv
